// ===== rtl/scpt_pkg.sv =====
// ----------------------------------------------------------------------------
// scpt_pkg: shared definitions for the sound CPU I/O page
// Command codes, page offsets, reset constants and the request and
// response structures passed between the top level and its sub-blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package scpt_pkg;

  // Default number of implemented timers.
  localparam int NUM_TIMERS_DEF = 3;

  // Command codes carried by each input transaction.
  typedef enum logic [2:0] {
    CMD_CPU_RD  = 3'd0,
    CMD_CPU_WR  = 3'd1,
    CMD_HOST_RD = 3'd2,
    CMD_HOST_WR = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_t;

  // Offsets within the I/O page (page base 0xF0).
  localparam logic [3:0] OFF_CTRL  = 4'h1;  // 0xF1 control
  localparam logic [3:0] OFF_DSP   = 4'h3;  // 0xF3 DSP data forward
  localparam logic [3:0] OFF_PORT0 = 4'h4;  // 0xF4 first mailbox port
  localparam logic [3:0] OFF_PORT3 = 4'h7;  // last mailbox port
  localparam logic [3:0] OFF_TGT0  = 4'hA;  // 0xFA first timer target
  localparam logic [3:0] OFF_TGT2  = 4'hC;  // last timer target
  localparam logic [3:0] OFF_CNT0  = 4'hD;  // 0xFD first timer counter

  // Control register bit positions for the mailbox clears.
  localparam int CTRL_CLR_LO_BIT = 4;
  localparam int CTRL_CLR_HI_BIT = 5;

  // Request to the timer bank.
  typedef struct packed {
    logic       tick;
    logic       ctrl_wr;
    logic       tgt_wr;
    logic [1:0] idx;
    logic [7:0] data;
  } tmr_req_t;

  // Read-back from the timer bank for the selected timer.
  typedef struct packed {
    logic [7:0] target;
    logic [7:0] count;
  } tmr_rsp_t;

  // Request to the mailbox ports.
  typedef struct packed {
    logic       cpu_wr;   // CPU writes a CPU-to-host byte
    logic       host_wr;  // host writes a host-to-CPU byte
    logic       clr_lo;   // clear ports 0 and 1, both directions
    logic       clr_hi;   // clear ports 2 and 3, both directions
    logic [1:0] idx;
    logic [7:0] data;
  } mbx_req_t;

  // Read-back from the mailbox ports at the requested index.
  typedef struct packed {
    logic [7:0] h2c;
    logic [7:0] c2h;
  } mbx_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/scpt_timers.sv =====
// ----------------------------------------------------------------------------
// scpt_timers: prescaled timer bank
// Holds enable, target, prescaler and counter for each timer and advances
// every enabled timer on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module scpt_timers
  import scpt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tmr_req_t req,
  output tmr_rsp_t      rsp
);

  logic       enable_r   [NUM_TIMERS];
  logic [7:0] target_r   [NUM_TIMERS];
  logic [7:0] prescale_r [NUM_TIMERS];
  logic [7:0] count_r    [NUM_TIMERS];

  // Timer state; every timer wraps at 8 bits.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
    logic [7:0] pre_inc;
    assign pre_inc = prescale_r[i] + 8'd1;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        enable_r[i]   <= 1'b0;
        target_r[i]   <= 8'd0;
        prescale_r[i] <= 8'd0;
        count_r[i]    <= 8'd0;
      end else begin
        if (req.ctrl_wr) begin
          enable_r[i] <= req.data[i];
        end
        if (req.tgt_wr && (req.idx == 2'(i))) begin
          target_r[i] <= req.data;
        end
        if (req.tick && enable_r[i]) begin
          if (pre_inc == target_r[i]) begin
            prescale_r[i] <= 8'd0;
            count_r[i]    <= count_r[i] + 8'd1;
          end else begin
            prescale_r[i] <= pre_inc;
          end
        end
      end
    end
  end

  // Read-back of the selected timer.
  always_comb begin
    rsp = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (req.idx == 2'(i)) begin
        rsp.target = target_r[i];
        rsp.count  = count_r[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scpt_mailbox.sv =====
// ----------------------------------------------------------------------------
// scpt_mailbox: host/CPU mailbox ports
// Four host-to-CPU and four CPU-to-host bytes, with pairwise clears driven
// by the control register.
// ----------------------------------------------------------------------------
`default_nettype none

module scpt_mailbox
  import scpt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mbx_req_t req,
  output mbx_rsp_t      rsp
);

  logic [7:0] h2c_r [4];
  logic [7:0] c2h_r [4];

  // Port bytes; a clear of a pair takes both directions.
  for (genvar i = 0; i < 4; i++) begin : g_port
    logic clr;
    assign clr = (i < 2) ? req.clr_lo : req.clr_hi;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        h2c_r[i] <= 8'd0;
        c2h_r[i] <= 8'd0;
      end else begin
        if (clr) begin
          h2c_r[i] <= 8'd0;
          c2h_r[i] <= 8'd0;
        end else begin
          if (req.host_wr && (req.idx == 2'(i))) begin
            h2c_r[i] <= req.data;
          end
          if (req.cpu_wr && (req.idx == 2'(i))) begin
            c2h_r[i] <= req.data;
          end
        end
      end
    end
  end

  // Read-back at the requested index.
  assign rsp.h2c = h2c_r[req.idx];
  assign rsp.c2h = c2h_r[req.idx];

endmodule

`default_nettype wire

// ===== rtl/sound_cpu_io_ports_and_timers.sv =====
// ----------------------------------------------------------------------------
// sound_cpu_io_ports_and_timers: I/O page of the sound processor
// Mailbox ports, prescaled timers and the DSP write forward, driven by one
// command per transaction.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while no stall holds it, and
// returns exactly one result for each, in order. A transaction is captured
// in the input register, then decoded and applied to the mailbox and timer
// state as it moves into the result register, which presents its result.
// The rate of one transaction per clock is set by that single decode step;
// a stalled result register holds the input register, which then stalls
// the input channel. Commands: CPU read, CPU write, host read, host write
// and tick; unhandled CPU offsets return bad_access with zero data.
`default_nettype none

module sound_cpu_io_ports_and_timers
  import scpt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_cmd,
  input  wire logic [3:0] in_reg_offset,
  input  wire logic [1:0] in_host_port,
  input  wire logic [7:0] in_wdata,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_rdata,
  output logic            out_bad_access,
  output logic            out_dsp_write_valid,
  output logic [7:0]      out_dsp_write_data
);

  logic       s1_valid_r;
  logic [2:0] s1_cmd_r;
  logic [3:0] s1_off_r;
  logic [1:0] s1_port_r;
  logic [7:0] s1_data_r;

  logic       out_valid_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic       bad_r, bad_nxt;
  logic       dv_r, dv_nxt;
  logic [7:0] dd_r, dd_nxt;

  logic       advance;
  tmr_req_t   tmr_req;
  tmr_rsp_t   tmr_rsp;
  mbx_req_t   mbx_req;
  mbx_rsp_t   mbx_rsp;

  // The input register moves on when the result register is free or drained.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r  <= in_cmd;
      s1_off_r  <= in_reg_offset;
      s1_port_r <= in_host_port;
      s1_data_r <= in_wdata;
    end
  end

  // Command decode, state update requests and result formation.
  always_comb begin
    logic       in_port;
    logic       in_tgt;
    logic       in_cnt;
    logic [1:0] tidx;
    logic       t_ok;

    in_port = (s1_off_r >= OFF_PORT0) && (s1_off_r <= OFF_PORT3);
    in_tgt  = (s1_off_r >= OFF_TGT0) && (s1_off_r <= OFF_TGT2);
    in_cnt  = (s1_off_r >= OFF_CNT0);
    tidx    = in_tgt ? 2'(s1_off_r - OFF_TGT0) : 2'(s1_off_r - OFF_CNT0);
    t_ok    = 32'(tidx) < NUM_TIMERS;

    tmr_req      = '0;
    tmr_req.idx  = tidx;
    tmr_req.data = s1_data_r;
    mbx_req      = '0;
    mbx_req.idx  = s1_off_r[1:0];
    mbx_req.data = s1_data_r;

    rdata_nxt = 8'd0;
    bad_nxt   = 1'b0;
    dv_nxt    = 1'b0;
    dd_nxt    = 8'd0;

    unique case (s1_cmd_r)
      CMD_CPU_RD: begin
        if (in_port) begin
          rdata_nxt = mbx_rsp.h2c;
        end else if (in_tgt && t_ok) begin
          rdata_nxt = tmr_rsp.target;
        end else if (in_cnt && t_ok) begin
          rdata_nxt = tmr_rsp.count;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      CMD_CPU_WR: begin
        if (s1_off_r == OFF_CTRL) begin
          tmr_req.ctrl_wr = advance;
          mbx_req.clr_lo  = advance && s1_data_r[CTRL_CLR_LO_BIT];
          mbx_req.clr_hi  = advance && s1_data_r[CTRL_CLR_HI_BIT];
        end else if (s1_off_r == OFF_DSP) begin
          dv_nxt = 1'b1;
          dd_nxt = s1_data_r;
        end else if (in_port) begin
          mbx_req.cpu_wr = advance;
        end else if (in_tgt && t_ok) begin
          tmr_req.tgt_wr = advance;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      CMD_HOST_RD: begin
        mbx_req.idx = s1_port_r;
        rdata_nxt   = mbx_rsp.c2h;
      end
      CMD_HOST_WR: begin
        mbx_req.idx     = s1_port_r;
        mbx_req.host_wr = advance;
      end
      CMD_TICK: begin
        tmr_req.tick = advance;
      end
      default: begin
      end
    endcase
  end

  scpt_mailbox u_mailbox (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mbx_req),
    .rsp   (mbx_rsp)
  );

  scpt_timers #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_timers (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tmr_req),
    .rsp   (tmr_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rdata_r <= rdata_nxt;
      bad_r   <= bad_nxt;
      dv_r    <= dv_nxt;
      dd_r    <= dd_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rdata           = rdata_r;
  assign out_bad_access      = bad_r;
  assign out_dsp_write_valid = dv_r;
  assign out_dsp_write_data  = dd_r;

  // A DSP forward is never also an unhandled access.
  a_dsp_not_bad : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_bad_access && out_dsp_write_valid))
    else $error("DSP forward flagged as bad access");

  // Forward data is zero unless a forward is signalled.
  a_dsp_data_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dsp_write_valid) |-> (out_dsp_write_data == 8'd0))
    else $error("DSP data without a DSP forward");

  // An unhandled access reads as zero.
  a_bad_rdata_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_access) |-> (out_rdata == 8'd0))
    else $error("Bad access returned non-zero data");

  // The input side stalls only behind a held result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_valid_r))
    else $error("Input stalled without a held result");

endmodule

`default_nettype wire
